// ===== sv/sorted_priority_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Request kinds, result status codes and the update control struct.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int KeyW    = 32;
  localparam int CountW  = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  // Update command broadcast to every cell in the same cycle.
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_ctl_t;

endpackage

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One stored key with its comparators and its shift-in / shift-out mux.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                            clk,
  input  logic                            occupied,
  input  logic                            le_prev,
  input  logic signed [spq_pkg::KeyW-1:0] prev_entry,
  input  logic signed [spq_pkg::KeyW-1:0] next_entry,
  input  logic signed [spq_pkg::KeyW-1:0] value,
  input  spq_pkg::spq_ctl_t               ctl,
  output logic signed [spq_pkg::KeyW-1:0] entry,
  output logic                            le,
  output logic                            lt,
  output logic                            eq
);
  import spq_pkg::*;

  logic signed [KeyW-1:0] entry_next;

  assign le = occupied && (entry <= value);
  assign lt = occupied && (entry < value);
  assign eq = occupied && (entry == value);

  // Entries are sorted, so le and lt form prefixes across the row.
  always_comb begin
    entry_next = entry;
    if (ctl.ins && !le) begin
      entry_next = le_prev ? value : prev_entry;
    end else if (ctl.rem && !lt) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== sv/spq_array.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell array
// Row of cells, match reduction and next head selection.
// ----------------------------------------------------------------------------
module spq_array #(
  parameter  int CAPACITY = 16,
  localparam int FillW    = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic [FillW-1:0]                fill,
  input  logic signed [spq_pkg::KeyW-1:0] value,
  input  spq_pkg::spq_ctl_t               ctl,
  output logic                            hit,
  output logic signed [spq_pkg::KeyW-1:0] head_next
);
  import spq_pkg::*;

  logic signed [KeyW-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]    le;
  logic [CAPACITY-1:0]    lt;
  logic [CAPACITY-1:0]    eq;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   occupied;
    logic                   le_prev;
    logic signed [KeyW-1:0] prev_entry;
    logic signed [KeyW-1:0] next_entry;

    assign occupied = fill > FillW'(i);

    if (i == 0) begin : g_first
      assign le_prev    = 1'b1;
      assign prev_entry = value;
    end else begin : g_mid
      assign le_prev    = le[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = entry[i];
    end else begin : g_inner
      assign next_entry = entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .occupied   (occupied),
      .le_prev    (le_prev),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .value      (value),
      .ctl        (ctl),
      .entry      (entry[i]),
      .le         (le[i]),
      .lt         (lt[i]),
      .eq         (eq[i])
    );
  end

  assign hit = |eq;

  always_comb begin
    head_next = entry[0];
    if (ctl.ins && !le[0]) begin
      head_next = value;
    end else if (ctl.rem && !lt[0]) begin
      head_next = entry[1];
    end
  end

endmodule

// ===== sv/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue
// Path: a request is held in the input register, then in the result register.
// Throughput: one request per cycle while rsp_stall is low; every cell compares and shifts at once.
// Reset (rst, synchronous): empties the queue and drops any pending transfers.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Request channel
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [1:0]                      kind,
  input  logic signed [spq_pkg::KeyW-1:0] value,
  // Result channel
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [1:0]                      status,
  output logic                            head_valid,
  output logic signed [spq_pkg::KeyW-1:0] head_value,
  output logic [spq_pkg::CountW-1:0]      count
);
  import spq_pkg::*;

  localparam int FillW = $clog2(CAPACITY + 1);

  // Input register: holds one accepted request until the result slot is free.
  logic                   in_valid;
  logic [1:0]             in_kind;
  logic signed [KeyW-1:0] in_value;

  // Number of held entries. The keys themselves live in the cell array.
  logic [FillW-1:0]       fill;
  logic [FillW-1:0]       fill_next;

  logic                   advance;
  logic                   full;
  logic                   hit;
  logic                   req_take;
  spq_ctl_t               ctl;
  logic signed [KeyW-1:0] head_next;
  logic [1:0]             status_next;
  logic [31:0]            fill_wide;

  // A request moves into the result register when the result slot is empty
  // or its current result is being taken in this cycle. The input register
  // stalls only while it is full and cannot move on.
  assign advance   = in_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = in_valid && !advance;
  assign req_take  = req_valid && !req_stall;

  assign full = (fill == FillW'(CAPACITY));

  // Cells update only when the request really commits a change.
  assign ctl.ins = advance && (in_kind == KIND_INSERT) && !full;
  assign ctl.rem = advance && (in_kind == KIND_REMOVE) && hit;

  spq_array #(
    .CAPACITY (CAPACITY)
  ) u_array (
    .clk       (clk),
    .fill      (fill),
    .value     (in_value),
    .ctl       (ctl),
    .hit       (hit),
    .head_next (head_next)
  );

  always_comb begin
    fill_next = fill;
    if (ctl.ins) begin
      fill_next = fill + 1'b1;
    end else if (ctl.rem) begin
      fill_next = fill - 1'b1;
    end
  end

  // Kind three is unused; it changes nothing and reports a miss.
  always_comb begin
    case (in_kind)
      KIND_INSERT: status_next = full ? STATUS_FULL : STATUS_DONE;
      KIND_REMOVE: status_next = hit ? STATUS_DONE : STATUS_MISS;
      KIND_FIND:   status_next = hit ? STATUS_DONE : STATUS_MISS;
      default:     status_next = STATUS_MISS;
    endcase
  end

  // The count port carries the fill level modulo 32.
  assign fill_wide = 32'(fill_next);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      fill      <= '0;
    end else begin
      if (req_take) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      fill <= fill_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_take) begin
      in_kind  <= kind;
      in_value <= value;
    end
    if (advance) begin
      status     <= status_next;
      head_valid <= (fill_next != '0);
      head_value <= (fill_next != '0) ? head_next : '0;
      count      <= fill_wide[CountW-1:0];
    end
  end

  `SPQ_ASSERT_SAME(a_fill_bound, 1'b1, fill <= FillW'(CAPACITY), "fill above capacity")
  `SPQ_ASSERT_SAME(a_stall_cause, req_stall, rsp_valid && rsp_stall,
                   "stall without backpressure")
  `SPQ_ASSERT_SAME(a_edit_needs_item, ctl.ins || ctl.rem, advance,
                   "cell update without a request")
  `SPQ_ASSERT_NEXT(a_insert_grows, ctl.ins, fill == $past(fill) + 1'b1,
                   "insert did not grow fill")
  `SPQ_ASSERT_NEXT(a_full_result, advance && full && in_kind == KIND_INSERT,
                   status == STATUS_FULL && fill == FillW'(CAPACITY),
                   "full insert not refused")

endmodule
